// File: hw/rtl/vcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared widths, command and status types for the cosine similarity block.
// ----------------------------------------------------------------------------
package vcs_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int FRAC_DEF     = 12;
  localparam int MAXLEN_DEF   = 1024;
  localparam int DOT_W        = 42;
  localparam int SQ_W         = 41;
  localparam int OUT_FRAC     = 14;
  localparam int OUT_W        = 16;
  localparam int MAG_W        = OUT_FRAC + 1;
  // dot^2 fits in 84 bits, shifted by 2*OUT_FRAC+2 gives 114; product of sums is 82 bits
  localparam int WIDE_W       = 2 * DOT_W + 2 * OUT_FRAC + 2;
  localparam int PROD_W       = 2 * SQ_W;
  localparam int PART_W       = 21;

  // controller to datapath
  typedef struct packed {
    logic acc_en;      // accumulate the input pair
    logic acc_clr;     // clear accumulators
    logic snap;        // capture accumulators for the final stage
    logic mul_step;    // advance the wide multiplier one partial product
    logic mul_sel;     // 0: dot^2, 1: sum_a*sum_b
    logic srch_init;   // start the magnitude search
    logic srch_sq;     // square the odd candidate, clear the product sum
    logic srch_mac;    // add one partial product of odd^2 * prod
    logic srch_step;   // compare and narrow the search interval
    logic res_load;    // load result register
  } vcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero;        // either norm is zero
    logic srch_done;   // search interval closed
  } vcs_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/vector_cosine_similarity.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_cosine_similarity
// Streaming cosine similarity of two fixed-point vectors.
// ----------------------------------------------------------------------------
// One element pair is taken per cycle while a vector streams in; the pair
// marked tlast ends the vector. After it the block stops taking requests
// while it lets the last product land, snapshots the accumulators, runs
// four 21x21 partial products each for dot^2 and the product of the norms,
// starts the search, runs n search steps (square the candidate, four
// partial products, compare; n is 14 or 15), sees the search close and
// loads the result. With a zero norm the search is skipped. One result
// request is then held on the master side until taken, and a result still
// waiting there holds off the next load; zero_norm forces similarity 0.
// ----------------------------------------------------------------------------
module vector_cosine_similarity
  import vcs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [2*ELEMENT_WIDTH-1:0] s_tdata,  // elem_a, elem_b
  input  wire logic         s_tlast,                // last
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [OUT_W-1:0]  m_tdata,                // similarity
  output logic              m_tuser                 // zero_norm
);

  vcs_cmd_t cmd;
  vcs_sts_t sts;
  logic     in_fire, set_v;
  logic signed [OUT_W-1:0] sim;

  assign in_fire = s_tvalid && s_tready;

  vcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(s_tlast),
    .out_busy(m_tvalid && !m_tready), .sts(sts), .in_rdy(s_tready),
    .res_valid_set(set_v), .cmd(cmd)
  );

  vcs_dpath u_dp (
    .clk(clk),
    .rst(rst),
    .a_in(s_tdata[ELEMENT_WIDTH-1:0]),
    .b_in(s_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]),
    .cmd(cmd), .sts(sts), .sim(sim), .zflag(m_tuser)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (set_v) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = sim;

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero norm with nonzero similarity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}))
    else $error("result changed while waiting");

endmodule
`default_nettype wire

// File: hw/rtl/vcs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_ctrl
// Sequencer: accumulate pairs, then run the wide multiplies and the search.
// ----------------------------------------------------------------------------
module vcs_ctrl
  import vcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_fire,
  input  wire logic     in_last,
  input  wire logic     out_busy,
  input  vcs_sts_t      sts,
  output logic          in_rdy,
  output logic          res_valid_set,
  output vcs_cmd_t      cmd
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_MULA = 3'd1;
  localparam logic [2:0] S_MULB = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SRW  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;   // sub-step count, 0..5

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    in_rdy        = 1'b0;
    res_valid_set = 1'b0;
    case (state)
      S_ACC: begin
        in_rdy     = 1'b1;
        cmd.acc_en = in_fire;
        if (in_fire && in_last) begin
          state_next = S_MULA;
          step_next  = '0;
        end
      end
      S_MULA: begin
        if (step == 3'd0) begin
          // let the last product land in the accumulators
          step_next = 3'd1;
        end else if (step == 3'd1) begin
          cmd.snap    = 1'b1;
          cmd.acc_clr = 1'b1;
          step_next   = 3'd2;
        end else begin
          cmd.mul_step = 1'b1;
          cmd.mul_sel  = 1'b0;
          if (step == 3'd5) begin
            step_next  = '0;
            state_next = S_MULB;
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      S_MULB: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel  = 1'b1;
        if (step == 3'd3) begin
          step_next  = '0;
          state_next = S_SRCH;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_SRCH: begin
        cmd.srch_init = 1'b1;
        state_next    = S_SRW;
      end
      S_SRW: begin
        // one search step: square, four partial products, compare
        if (step == 3'd0 && (sts.srch_done || sts.zero)) begin
          state_next = S_DONE;
        end else begin
          case (step)
            3'd0:    cmd.srch_sq   = 1'b1;
            3'd5:    cmd.srch_step = 1'b1;
            default: cmd.srch_mac  = 1'b1;
          endcase
          step_next = (step == 3'd5) ? 3'd0 : step + 3'd1;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.res_load  = 1'b1;
          res_valid_set = 1'b1;
          state_next    = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/vcs_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_dpath
// Accumulators, partial-product multiplier and the magnitude search.
// ----------------------------------------------------------------------------
module vcs_dpath
  import vcs_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic signed [ELEMENT_WIDTH-1:0] a_in,
  input  wire logic signed [ELEMENT_WIDTH-1:0] b_in,
  input  vcs_cmd_t                             cmd,
  output vcs_sts_t                             sts,
  output logic signed [OUT_W-1:0]              sim,
  output logic                                 zflag
);

  localparam int PW = 2 * ELEMENT_WIDTH;
  localparam logic signed [DOT_W:0] DMAX = {2'b00, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W:0] DMIN = {2'b11, {(DOT_W-1){1'b0}}};
  localparam logic [SQ_W:0] SMAX = {1'b0, {SQ_W{1'b1}}};

  // stage 1: register products
  logic signed [PW-1:0] p_ab;
  logic        [PW-1:0] p_aa, p_bb;
  logic                 p_v;
  logic signed [DOT_W-1:0] dot_acc;
  logic        [SQ_W-1:0]  sum_a, sum_b;
  logic signed [DOT_W:0]   d_sum;
  logic        [SQ_W:0]    a_sum, b_sum;

  always_ff @(posedge clk) begin
    p_ab <= a_in * b_in;
    p_aa <= PW'(a_in * a_in);
    p_bb <= PW'(b_in * b_in);
  end

  // acc_en marks a product arriving next cycle; keep a valid delay
  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else     p_v <= cmd.acc_en;
  end

  always_comb begin
    d_sum = {dot_acc[DOT_W-1], dot_acc} + (DOT_W+1)'(p_ab);
    a_sum = {1'b0, sum_a} + (SQ_W+1)'(p_aa);
    b_sum = {1'b0, sum_b} + (SQ_W+1)'(p_bb);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clr) begin
      dot_acc <= '0;
      sum_a   <= '0;
      sum_b   <= '0;
    end else if (p_v) begin
      dot_acc <= (d_sum > DMAX) ? DMAX[DOT_W-1:0] :
                 (d_sum < DMIN) ? DMIN[DOT_W-1:0] : d_sum[DOT_W-1:0];
      sum_a   <= (a_sum > SMAX) ? SMAX[SQ_W-1:0] : a_sum[SQ_W-1:0];
      sum_b   <= (b_sum > SMAX) ? SMAX[SQ_W-1:0] : b_sum[SQ_W-1:0];
    end
  end

  // snapshot, taken once the last product has landed
  logic [DOT_W-1:0] mag;
  logic             neg;
  logic [SQ_W-1:0]  sa, sb;
  logic             zero;
  logic [1:0]       pidx;

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      neg  <= dot_acc[DOT_W-1];
      mag  <= dot_acc[DOT_W-1] ? DOT_W'(-dot_acc) : DOT_W'(dot_acc);
      sa   <= sum_a;
      sb   <= sum_b;
      zero <= (sum_a == '0) || (sum_b == '0);
    end
  end

  // wide multiply, one 21x21 partial product per step
  logic [WIDE_W-1:0] rhs;
  logic [PROD_W-1:0] prod;
  logic [PART_W-1:0] xa, ya;
  logic [2*PART_W-1:0] pp;
  logic [7:0]        sh;
  logic [SQ_W:0]     xop, yop;

  always_comb begin
    xop = cmd.mul_sel ? {1'b0, sa} : {1'b0, mag[SQ_W-1:0]} | {mag[DOT_W-1], {SQ_W{1'b0}}};
    yop = cmd.mul_sel ? {1'b0, sb} : {1'b0, mag[SQ_W-1:0]} | {mag[DOT_W-1], {SQ_W{1'b0}}};
    xa  = pidx[0] ? xop[2*PART_W-1:PART_W] : xop[PART_W-1:0];
    ya  = pidx[1] ? yop[2*PART_W-1:PART_W] : yop[PART_W-1:0];
    pp  = xa * ya;
    sh  = 8'((32'(pidx[0]) + 32'(pidx[1])) * PART_W);
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      pidx <= '0;
      rhs  <= '0;
      prod <= '0;
    end else if (cmd.mul_step) begin
      pidx <= pidx + 2'd1;
      if (cmd.mul_sel) prod <= prod + (PROD_W'(pp) << sh);
      else             rhs  <= rhs + (WIDE_W'(pp) << (sh + 8'(2*OUT_FRAC+2)));
    end
  end

  // binary search: largest r with (2r-1)^2 * prod <= rhs
  // odd^2 * prod is summed from four 21-bit slices of prod
  logic [MAG_W-1:0]          lo, hi, mid;
  logic [MAG_W:0]            odd;
  logic [2*MAG_W+1:0]        osq;
  logic [1:0]                sidx;
  logic [4*PART_W-1:0]       prod_x;
  logic [PART_W-1:0]         pchunk;
  logic [PART_W+2*MAG_W+1:0] spp;
  logic [7:0]                ssh;
  logic [WIDE_W-1:0]         lhs;
  logic                      ok;

  always_comb begin
    mid    = MAG_W'(({1'b0, lo} + {1'b0, hi} + (MAG_W+1)'(1)) >> 1);
    odd    = {mid, 1'b0} - (MAG_W+1)'(1);
    prod_x = (4*PART_W)'(prod);
    case (sidx)
      2'd0:    pchunk = prod_x[PART_W-1:0];
      2'd1:    pchunk = prod_x[2*PART_W-1:PART_W];
      2'd2:    pchunk = prod_x[3*PART_W-1:2*PART_W];
      default: pchunk = prod_x[4*PART_W-1:3*PART_W];
    endcase
    spp = pchunk * osq;
    ssh = 8'(32'(sidx) * PART_W);
    ok  = lhs <= rhs;
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_sq) begin
      osq  <= odd * odd;
      sidx <= '0;
      lhs  <= '0;
    end else if (cmd.srch_mac) begin
      sidx <= sidx + 2'd1;
      lhs  <= lhs + (WIDE_W'(spp) << ssh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= MAG_W'(1 << OUT_FRAC);
    end else if (cmd.srch_step) begin
      if (ok) lo <= mid;
      else    hi <= mid - MAG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      zflag <= zero;
      if (zero) sim <= '0;
      else      sim <= neg ? OUT_W'(-{1'b0, lo}) : OUT_W'({1'b0, lo});
    end
  end

  assign sts.zero      = zero;
  assign sts.srch_done = (lo == hi);

endmodule
`default_nettype wire
